// File: src/utf8_stream_decoder_unit_macros.svh
// Assertion macros shared by the UTF-8 stream decoder modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define UTF8SD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("utf8sd assertion failed");

// Next-cycle implication, disabled while reset is active.
`define UTF8SD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("utf8sd assertion failed");

`endif

// File: src/utf8sd_pkg.sv
// Types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package utf8sd_pkg;

    localparam logic [20:0] REPL_CP       = 21'h00FFFD;
    localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
    localparam logic [7:0]  LEAD_2_MIN    = 8'hC2;
    localparam logic [7:0]  LEAD_3_MIN    = 8'hE0;
    localparam logic [7:0]  LEAD_4_MIN    = 8'hF0;
    localparam logic [7:0]  LEAD_MAX      = 8'hF4;
    localparam logic [7:0]  E0_SECOND_MIN = 8'hA0;
    localparam logic [7:0]  F0_SECOND_MIN = 8'h90;
    localparam logic [7:0]  F4_SECOND_MAX = 8'h8F;
    localparam logic [7:0]  CONT_MASK     = 8'hC0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  bytes_consumed;
        logic        replaced;
        logic        last_of_run;
    } out_beat_t;

    // Results of one input byte: pre replacements, optional main result,
    // post (end of text) replacements. Main result sits at index main_pos.
    typedef struct packed {
        logic [2:0]  cnt;
        logic        main_valid;
        logic [1:0]  main_pos;
        logic [20:0] main_cp;
        logic [2:0]  main_bytes;
        logic        main_repl;
    } plan_t;

endpackage

// File: src/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: byte channel in, code point channel out.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_outbuf.

// Decodes a UTF-8 byte stream into code points, substituting U+FFFD (replaced = 1)
// for malformed bytes and flushing any open sequence when end_of_text is set.
// A byte is decoded in the cycle it is accepted, and its results (zero to four)
// leave from a result register one beat per cycle while m_ready is high. A byte giving
// at most one result does not hold the input, so clean text streams at one byte per
// cycle while m_ready is high; a byte giving more holds the input while the register drains.
// last_of_run marks the final result of each byte.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    plan_t plan;
    logic  accept;

    assign accept = s_valid && s_ready;

    utf8sd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_beat (s_data),
        .plan    (plan)
    );

    utf8sd_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .plan     (plan),
        .can_load (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: src/utf8sd_decode.sv
// Sequence state registers and per-byte decode into a result plan.
// Depends on utf8sd_pkg and utf8_stream_decoder_unit_macros.svh.
`include "utf8_stream_decoder_unit_macros.svh"

module utf8sd_decode
    import utf8sd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  in_beat_t in_beat,
    output plan_t    plan
);

    logic [1:0]  held_reg,    held_next;
    logic [2:0]  expect_reg,  expect_next;
    logic [7:0]  lead_reg,    lead_next;
    logic [20:0] partial_reg, partial_next;

    logic [7:0]  b;
    logic        sl_ascii, sl_open;
    logic [2:0]  sl_expect;
    logic [20:0] sl_part;
    logic        ok, fail, use_lead, complete;
    logic [2:0]  held_inc;
    logic [20:0] part_shift;
    logic [1:0]  held_mid;
    logic [2:0]  expect_mid;
    logic [7:0]  lead_mid;
    logic [20:0] part_mid;
    logic [1:0]  pre_cnt, post_cnt;

    always_comb begin
        b          = in_beat.text_byte;
        sl_ascii   = b < ASCII_LIMIT;
        sl_open    = (b >= LEAD_2_MIN) && (b <= LEAD_MAX);
        if (b < LEAD_3_MIN) begin
            sl_expect = 3'd2;
            sl_part   = {16'd0, b[4:0]};
        end else if (b < LEAD_4_MIN) begin
            sl_expect = 3'd3;
            sl_part   = {17'd0, b[3:0]};
        end else begin
            sl_expect = 3'd4;
            sl_part   = {18'd0, b[2:0]};
        end

        ok = (b & CONT_MASK) == CONT_TAG;
        if (held_reg == 2'd1) begin
            if (lead_reg == LEAD_3_MIN && b < E0_SECOND_MIN) ok = 1'b0;
            if (lead_reg == LEAD_4_MIN && b < F0_SECOND_MIN) ok = 1'b0;
            if (lead_reg == LEAD_MAX && b > F4_SECOND_MAX) ok = 1'b0;
        end
        fail       = (held_reg != 2'd0) && !ok;
        use_lead   = (held_reg == 2'd0) || fail;
        part_shift = {partial_reg[14:0], b[5:0]};
        held_inc   = {1'b0, held_reg} + 3'd1;
        complete   = held_inc >= expect_reg;

        plan.main_valid = 1'b0;
        plan.main_cp    = REPL_CP;
        plan.main_bytes = 3'd1;
        plan.main_repl  = 1'b0;
        held_mid   = '0;
        expect_mid = '0;
        lead_mid   = '0;
        part_mid   = '0;
        if (use_lead) begin
            if (sl_open) begin
                held_mid   = 2'd1;
                expect_mid = sl_expect;
                lead_mid   = b;
                part_mid   = sl_part;
            end else begin
                plan.main_valid = 1'b1;
                plan.main_cp    = sl_ascii ? {13'd0, b} : REPL_CP;
                plan.main_repl  = !sl_ascii;
            end
        end else if (complete) begin
            plan.main_valid = 1'b1;
            plan.main_cp    = part_shift;
            plan.main_bytes = expect_reg;
        end else begin
            held_mid   = held_inc[1:0];
            expect_mid = expect_reg;
            lead_mid   = lead_reg;
            part_mid   = part_shift;
        end

        pre_cnt  = fail ? held_reg : 2'd0;
        post_cnt = in_beat.end_of_text ? held_mid : 2'd0;
        plan.cnt = {1'b0, pre_cnt} + {2'b0, plan.main_valid} + {1'b0, post_cnt};
        plan.main_pos = pre_cnt;

        if (in_beat.end_of_text) begin
            held_next    = '0;
            expect_next  = '0;
            lead_next    = '0;
            partial_next = '0;
        end else begin
            held_next    = held_mid;
            expect_next  = expect_mid;
            lead_next    = lead_mid;
            partial_next = part_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            expect_reg  <= '0;
            lead_reg    <= '0;
            partial_reg <= '0;
        end else if (accept) begin
            held_reg    <= held_next;
            expect_reg  <= expect_next;
            lead_reg    <= lead_next;
            partial_reg <= partial_next;
        end
    end

    `UTF8SD_ASSERT_IMPL(a_held_below_expect, aclk, aresetn, held_reg != 2'd0, {1'b0, held_reg} < expect_reg)
    `UTF8SD_ASSERT_NEXT(a_end_clears, aclk, aresetn, accept && in_beat.end_of_text, held_reg == 2'd0)
    `UTF8SD_ASSERT_IMPL(a_plan_bound, aclk, aresetn, accept, plan.cnt <= 3'd4)

endmodule

// File: src/utf8sd_outbuf.sv
// Result register: holds one byte's result plan and hands it out one beat per cycle while m_ready is high.
// Depends on utf8sd_pkg and utf8_stream_decoder_unit_macros.svh.
`include "utf8_stream_decoder_unit_macros.svh"

module utf8sd_outbuf
    import utf8sd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  plan_t     plan,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    plan_t      plan_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       last;
    logic       is_main;

    always_comb begin
        m_valid  = idx_reg != cnt_reg;
        last     = (idx_reg + 3'd1) == cnt_reg;
        can_load = !m_valid || (last && m_ready);
        is_main  = plan_reg.main_valid && (idx_reg[1:0] == plan_reg.main_pos);

        m_data.code_point     = is_main ? plan_reg.main_cp    : REPL_CP;
        m_data.bytes_consumed = is_main ? plan_reg.main_bytes : 3'd1;
        m_data.replaced       = is_main ? plan_reg.main_repl  : 1'b1;
        m_data.last_of_run    = last;

        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = plan.cnt;
            idx_next = '0;
        end else if (m_valid && m_ready) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg <= plan;
        end
    end

    `UTF8SD_ASSERT_IMPL(a_idx_in_range, aclk, aresetn, 1'b1, idx_reg <= cnt_reg && cnt_reg <= 3'd4)
    `UTF8SD_ASSERT_NEXT(a_drain_empties, aclk, aresetn, m_valid && m_ready && last && !load, !m_valid)
    `UTF8SD_ASSERT_NEXT(a_step_one, aclk, aresetn, m_valid && m_ready && !last, idx_reg == $past(idx_reg) + 3'd1)

endmodule

// File: tb/utf8_stream_decoder_unit_test.sv
// Self-checking bench for utf8_stream_decoder_unit: byte beats in, code point beats out.
// A built-in UTF-8 decoder predicts every result; directed and random text with idling.
// Depends on utf8sd_pkg and utf8_stream_decoder_unit.
module utf8_stream_decoder_unit_test;
    import utf8sd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_BYTES = 150;

    typedef logic [7:0] text_q_t[$];

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    utf8_stream_decoder_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // open sequence of the predicting decoder
    int unsigned held_cnt;
    int unsigned seq_len;
    logic [7:0]  seq_lead;
    logic [20:0] seq_bits;

    out_beat_t   step_cps[$];
    out_beat_t   expected_cps[$];
    int unsigned mismatches = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned rx_hold    = 0;
    bit          tx_quiet   = 1'b0;
    bit          rx_quiet   = 1'b0;

    function void clear_seq();
        held_cnt = 0;
        seq_len  = 0;
        seq_lead = '0;
        seq_bits = '0;
    endfunction

    function void push_cp(logic [20:0] cp, logic [2:0] n, logic repl);
        out_beat_t o;
        o.code_point     = cp;
        o.bytes_consumed = n;
        o.replaced       = repl;
        o.last_of_run    = 1'b0;
        step_cps.insert(step_cps.size(), o);
    endfunction

    function void open_seq(logic [7:0] b);
        if (b < ASCII_LIMIT) begin
            push_cp({13'd0, b}, 3'd1, 1'b0);
        end else if (b < LEAD_2_MIN || b > LEAD_MAX) begin
            push_cp(REPL_CP, 3'd1, 1'b1);
        end else begin
            held_cnt = 1;
            seq_lead = b;
            if (b < LEAD_3_MIN) begin
                seq_len  = 2;
                seq_bits = {16'd0, b[4:0]};
            end else if (b < LEAD_4_MIN) begin
                seq_len  = 3;
                seq_bits = {17'd0, b[3:0]};
            end else begin
                seq_len  = 4;
                seq_bits = {18'd0, b[2:0]};
            end
        end
    endfunction

    function void flush_seq();
        for (int unsigned i = 0; i < held_cnt; i++)
            push_cp(REPL_CP, 3'd1, 1'b1);
        clear_seq();
    endfunction

    function void decode_beat(logic [7:0] b, logic eot);
        bit ok;
        step_cps.delete();
        if (held_cnt == 0) begin
            open_seq(b);
        end else begin
            ok = (b & CONT_MASK) == CONT_TAG;
            if (held_cnt == 1) begin
                if (seq_lead == LEAD_3_MIN && b < E0_SECOND_MIN) ok = 1'b0;
                if (seq_lead == LEAD_4_MIN && b < F0_SECOND_MIN) ok = 1'b0;
                if (seq_lead == LEAD_MAX && b > F4_SECOND_MAX) ok = 1'b0;
            end
            if (!ok) begin
                flush_seq();
                open_seq(b);
            end else begin
                seq_bits = {seq_bits[14:0], b[5:0]};
                held_cnt++;
                if (held_cnt >= seq_len) begin
                    push_cp(seq_bits, 3'(seq_len), 1'b0);
                    clear_seq();
                end
            end
        end
        if (eot)
            flush_seq();
        if (step_cps.size() > 0)
            step_cps[step_cps.size() - 1].last_of_run = 1'b1;
        foreach (step_cps[i])
            expected_cps.insert(expected_cps.size(), step_cps[i]);
    endfunction

    // random code point of random length (surrogates included), UTF-8 encoded
    function automatic text_q_t encode_char();
        text_q_t     q;
        logic [20:0] cp;
        case ($urandom_range(1, 4))
            1: begin
                cp = 21'($urandom_range(0, 'h7F));
                q.insert(q.size(), cp[7:0]);
            end
            2: begin
                cp = 21'($urandom_range('h80, 'h7FF));
                q.insert(q.size(), {3'b110, cp[10:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            3: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                q.insert(q.size(), {4'b1110, cp[15:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
            default: begin
                cp = 21'($urandom_range('h10000, 'h10FFFF));
                q.insert(q.size(), {5'b11110, cp[20:18]});
                q.insert(q.size(), {2'b10, cp[17:12]});
                q.insert(q.size(), {2'b10, cp[11:6]});
                q.insert(q.size(), {2'b10, cp[5:0]});
            end
        endcase
        return q;
    endfunction

    task automatic send_beat(logic [7:0] b, logic eot);
        int unsigned gap;
        in_beat_t    beat;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        beat.text_byte   = b;
        beat.end_of_text = eot;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        decode_beat(b, eot);
    endtask

    task automatic send_text(text_q_t bytes, logic eot_last);
        foreach (bytes[i])
            send_beat(bytes[i], eot_last && i == bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_cps.size() != 0) @(posedge aclk);
    endtask

    task automatic test_malformed_leads();
        send_text('{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF}, 1'b0);
    endtask

    // largest scalar, literal U+FFFD, surrogate passes
    task automatic test_edge_scalars();
        send_text('{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hEF, 8'hBF, 8'hBD,
                    8'hED, 8'hA0, 8'h80}, 1'b0);
    endtask

    task automatic test_second_byte_ranges();
        send_text('{8'hE0, 8'h9F, 8'hF0, 8'h8F, 8'hF4, 8'h90}, 1'b0);
    endtask

    task automatic test_end_flush();
        send_text('{8'hC2, 8'h41}, 1'b0);
        send_text('{8'hF1, 8'h80, 8'h80, 8'hF2}, 1'b1);
    endtask

    task automatic test_random_text();
        int unsigned sent;
        int unsigned kind;
        text_q_t     seq;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 11) == 0) begin
                tx_quiet = $urandom_range(0, 2) == 0;
                rx_quiet = $urandom_range(0, 2) == 0;
            end
            kind = $urandom_range(0, 9);
            seq  = encode_char();
            if (kind == 7) begin
                seq.delete();
                seq.insert(0, 8'($urandom_range(0, 255)));
            end else if (kind == 8 && seq.size() > 1) begin
                seq = seq[0:$urandom_range(0, seq.size() - 2)];
            end else if (kind == 9) begin
                seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
            end
            foreach (seq[i])
                send_beat(seq[i], $urandom_range(0, 19) == 0);
            sent += seq.size();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    function void note_fault(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            rx_hold = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_cps.size() == 0) begin
                    note_fault($sformatf("unexpected beat: cp=%h n=%0d repl=%b last=%b",
                        m_data.code_point, m_data.bytes_consumed, m_data.replaced,
                        m_data.last_of_run));
                end else begin
                    want = expected_cps.pop_front();
                    if (m_data !== want)
                        note_fault($sformatf(
                            "mismatch: exp cp=%h n=%0d repl=%b last=%b, got cp=%h n=%0d repl=%b last=%b",
                            want.code_point, want.bytes_consumed, want.replaced,
                            want.last_of_run, m_data.code_point, m_data.bytes_consumed,
                            m_data.replaced, m_data.last_of_run));
                end
                rx_hold = rx_quiet ? 0 : $urandom_range(0, 7);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        clear_seq();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_malformed_leads();
        test_edge_scalars();
        test_second_byte_ranges();
        test_end_flush();
        wait_drained();
        test_random_text();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_cps.size() == 0) begin
            $display("utf8_stream_decoder_unit_test: PASS");
        end else begin
            $display("utf8_stream_decoder_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// File: utf8_stream_decoder_unit.f
+incdir+src
src/utf8sd_pkg.sv
src/utf8sd_decode.sv
src/utf8sd_outbuf.sv
src/utf8_stream_decoder_unit.sv
tb/utf8_stream_decoder_unit_test.sv
